@@ rtl/llcc_pkg.sv @@
// Shared constants, types and states of the lag-limited cross-correlator.
package llcc_pkg;

  localparam int MAX_LAG  = 15;
  localparam int NUM_LAGS = 2 * MAX_LAG + 1;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SUM_W    = 48;
  localparam int LAG_W    = 5;

  localparam int CNT_W    = $clog2(NUM_LAGS);
  localparam int PIDX_W   = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int LAGX_W   = (CNT_W + 1 > LAG_W) ? CNT_W + 1 : LAG_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [SUM_W:0]      sumx_t;
  typedef logic        [CNT_W-1:0]    cnt_t;
  typedef logic        [PIDX_W-1:0]   pidx_t;
  typedef logic signed [LAG_W-1:0]    lag_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam cnt_t LAST_IDX = cnt_t'(NUM_LAGS - 1);
  localparam cnt_t ZERO_IDX = cnt_t'(MAX_LAG);

  // Write-back from the multiply-accumulate unit into the lag sums.
  typedef struct packed {
    logic en;
    cnt_t idx;
    sum_t value;
  } llcc_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } llcc_state_e;

endpackage

@@ rtl/llcc_if.sv @@
// Valid/ready channel interfaces for sample pairs and correlation results.
interface llcc_in_if;
  import llcc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_a;
  sample_t sample_b;
  logic    is_final;

  modport source (output valid, output sample_a, output sample_b, output is_final,
                  input ready);
  modport sink   (input valid, input sample_a, input sample_b, input is_final,
                  output ready);
endinterface

interface llcc_out_if;
  import llcc_pkg::*;

  logic valid;
  logic ready;
  lag_t lag;
  sum_t corr_value;
  logic end_of_run;

  modport source (output valid, output lag, output corr_value, output end_of_run,
                  input ready);
  modport sink   (input valid, input lag, input corr_value, input end_of_run,
                  output ready);
endinterface

@@ rtl/llcc_mac.sv @@
// Shared multiply-accumulate unit: registered product, then saturating add.
module llcc_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               issue_i,
  input  llcc_pkg::cnt_t     idx_i,
  input  llcc_pkg::sample_t  op_x_i,
  input  llcc_pkg::sample_t  op_y_i,
  output llcc_pkg::cnt_t     rd_idx_o,
  input  llcc_pkg::sum_t     acc_i,
  output llcc_pkg::llcc_wr_t wr_o
);
  import llcc_pkg::*;

  logic  pvld_q;
  cnt_t  pidx_q;
  prod_t prod_q;
  prod_t prod_d;
  sumx_t sum_x;
  sum_t  sum_sat;

  assign prod_d = prod_t'(op_x_i) * prod_t'(op_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      pidx_q <= idx_i;
      prod_q <= prod_d;
    end
  end

  // Clamp when the carry into the guard bit disagrees with the sign bit.
  always_comb begin
    sum_x = sumx_t'(acc_i) + sumx_t'(prod_q);
    if (sum_x[SUM_W] != sum_x[SUM_W-1]) begin
      sum_sat = sum_x[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_x[SUM_W-1:0];
    end
  end

  assign rd_idx_o   = pidx_q;
  assign wr_o.en    = pvld_q;
  assign wr_o.idx   = pidx_q;
  assign wr_o.value = sum_sat;

endmodule

@@ rtl/lag_limited_cross_correlator_unit.sv @@
// Top level of the lag-limited cross-correlator.
//
//  channel  dir  payload                              beat accepted when
//  in_i     in   sample_a, sample_b, is_final         in_i.valid && in_i.ready
//  res_o    out  lag, corr_value, end_of_run          res_o.valid && res_o.ready
//
// A pair is taken in S_IDLE, then each lag in turn passes through the shared
// multiply-accumulate unit in S_MAC, and S_DRAIN retires the last product.
// A final pair then streams 2*MAX_LAG+1 results, one per cycle while res_o is ready,
// clearing each lag sum as it leaves; in_i.ready stays low until the last is loaded.
// Reset clears past samples, lag sums and the output valid flag at once.
// A stall on res_o holds the result beat; the emission pass waits on it.
module lag_limited_cross_correlator_unit (
  input logic         clk_i,
  input logic         rst_ni,
  llcc_in_if.sink     in_i,
  llcc_out_if.source  res_o
);
  import llcc_pkg::*;

  llcc_state_e state_q, state_d;
  cnt_t        cnt_q, cnt_d;

  sample_t a_q, b_q;
  logic    last_q;
  sample_t past_a_q [MAX_LAG];
  sample_t past_b_q [MAX_LAG];
  sum_t    sums_q   [NUM_LAGS];

  logic ovld_q;
  lag_t olag_q;
  sum_t osum_q;
  logic oend_q;

  logic load_in, issue, shift_past, clr_past, emit;

  cnt_t              off_pos, off_neg;
  sample_t           op_x, op_y;
  logic [LAGX_W-1:0] lag_full;
  cnt_t              mac_rd_idx;
  llcc_wr_t          mac_wr;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    load_in    = 1'b0;
    issue      = 1'b0;
    shift_past = 1'b0;
    clr_past   = 1'b0;
    emit       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          load_in = 1'b1;
          cnt_d   = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        issue = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      S_DRAIN: begin
        if (last_q) begin
          clr_past = 1'b1;
          cnt_d    = '0;
          state_d  = S_EMIT;
        end else begin
          shift_past = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ovld_q || res_o.ready) begin
          emit = 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + cnt_t'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (load_in) begin
      last_q <= in_i.is_final;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      a_q <= in_i.sample_a;
      b_q <= in_i.sample_b;
    end
  end

  // Operand select: lag 0 uses the current pair, positive lags past a,
  // negative lags past b.
  assign off_pos = cnt_q - cnt_t'(MAX_LAG + 1);
  assign off_neg = cnt_t'(MAX_LAG - 1) - cnt_q;

  always_comb begin
    if (cnt_q == ZERO_IDX) begin
      op_x = a_q;
      op_y = b_q;
    end else if (cnt_q > ZERO_IDX) begin
      op_x = b_q;
      op_y = past_a_q[off_pos[PIDX_W-1:0]];
    end else begin
      op_x = a_q;
      op_y = past_b_q[off_neg[PIDX_W-1:0]];
    end
  end

  llcc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .idx_i    (cnt_q),
    .op_x_i   (op_x),
    .op_y_i   (op_y),
    .rd_idx_o (mac_rd_idx),
    .acc_i    (sums_q[mac_rd_idx]),
    .wr_o     (mac_wr)
  );

  // Advance the delay lines after the pass; drop them at the end of a run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      past_a_q <= '{default: '0};
      past_b_q <= '{default: '0};
    end else if (clr_past) begin
      past_a_q <= '{default: '0};
      past_b_q <= '{default: '0};
    end else if (shift_past) begin
      past_a_q[0] <= a_q;
      past_b_q[0] <= b_q;
      for (int k = 1; k < MAX_LAG; k++) begin
        past_a_q[k] <= past_a_q[k-1];
        past_b_q[k] <= past_b_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '{default: '0};
    end else if (mac_wr.en) begin
      sums_q[mac_wr.idx] <= mac_wr.value;
    end else if (emit) begin
      sums_q[cnt_q] <= '0;
    end
  end

  // Output register
  assign lag_full = LAGX_W'(cnt_q) - LAGX_W'(MAX_LAG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (emit) begin
      ovld_q <= 1'b1;
    end else if (res_o.ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      olag_q <= lag_full[LAG_W-1:0];
      osum_q <= sums_q[cnt_q];
      oend_q <= (cnt_q == LAST_IDX);
    end
  end

  assign res_o.valid      = ovld_q;
  assign res_o.lag        = olag_q;
  assign res_o.corr_value = osum_q;
  assign res_o.end_of_run = oend_q;

  a_idle_no_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mac_wr.en)
    else $error("product write-back pending while taking a new beat");

  a_emit_no_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !mac_wr.en)
    else $error("lag sum write port used by both accumulate and clear");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == S_EMIT))
    else $error("result beat raised outside the emission pass");

  a_end_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.end_of_run) |-> (res_o.lag == lag_t'(MAX_LAG)))
    else $error("end of run flagged on a lag other than the greatest");

endmodule
